FILE: rtl/core/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");
`define ASSERT_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");
`endif

FILE: rtl/core/bsra_pkg.sv
package bsra_pkg;
   localparam int NUM_PROCS_DEF = 8;
   localparam int NUM_RES_DEF = 4;
   localparam int UNIT_BITS_DEF = 8;
   localparam int IN_UNIT_W = 8;
   localparam int PROC_W = 3;
   localparam int RES_W = 2;
   localparam int MODE_W = 3;
   localparam int STATUS_W = 3;

   localparam logic [MODE_W-1:0] MODE_TOTAL = 3'd0;
   localparam logic [MODE_W-1:0] MODE_MAX = 3'd1;
   localparam logic [MODE_W-1:0] MODE_ALLOC = 3'd2;
   localparam logic [MODE_W-1:0] MODE_REQ = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CHECK = 3'd4;

   localparam logic [STATUS_W-1:0] ST_LOADED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_GRANTED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_OVER_NEED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_UNAVAIL = 3'd3;
   localparam logic [STATUS_W-1:0] ST_UNSAFE = 3'd4;
   localparam logic [STATUS_W-1:0] ST_SAFE = 3'd5;
   localparam logic [STATUS_W-1:0] ST_DEADLOCK = 3'd6;

   typedef struct packed {
      logic load;       // latch item
      logic sum_clr;
      logic sum_step;   // add one allocation to column sum
      logic set_total;
      logic load_cell;  // max or alloc write
      logic need_step;  // refresh need of one resource
      logic apply_req;
      logic undo_req;
      logic scan_init;
      logic scan_step;
      logic rel_step;   // release one resource
      logic mark_fin;
   } ctl_type;

   typedef struct packed {
      logic over_need;
      logic over_avail;
      logic scan_fit;   // current process fits
      logic all_done;
      logic done_cand;
   } sts_type;
endpackage

FILE: rtl/core/bankers_safe_resource_allocator_unit.sv
// Banker's-algorithm resource guard.
// req_ channel: one beat per item; tuser holds the mode, tdata the
// process, resource, load value and four request amounts.
// rsp_ channel: one beat per item; tdata holds status, completed flag
// and the echoed process index.
// One item is handled at a time; req_tready is high only while idle.
// Ignored items and denied requests go from decode straight to the
// result beat; maximum and allocation loads then refresh the need of
// each resource; set total first sums the allocation column over the
// processes; a request or check runs the safety scan, a loop over the
// processes that restarts after each process that fits, and a granted
// request that completes its process then releases each resource.
// The result beat is held until rsp_tready; the next item is taken the
// cycle after the beat goes.
// Reset clears all tables and returns the block to idle at once.
`include "assert_macros.svh"
module bankers_safe_resource_allocator_unit
   import bsra_pkg::*;
#(
   parameter int NUM_PROCS = NUM_PROCS_DEF,
   parameter int NUM_RES = NUM_RES_DEF,
   parameter int UNIT_BITS = UNIT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // proc_id, res_id, load_value, request_0..3
   input  logic [2:0]  req_tuser,  // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata   // status, completed, proc_echo, zero pad
);
   localparam int PW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
   localparam int RW = (NUM_RES > 1) ? $clog2(NUM_RES) : 1;

   logic                in_fire;
   logic                busy, out_valid, completed;
   logic [STATUS_W-1:0] status;
   ctl_type             ctl;
   sts_type             sts;
   logic [PW-1:0]       proc_sel;
   logic [RW-1:0]       res_sel;
   logic [MODE_W-1:0]   mode_ff;
   logic [44:0]         data_ff;

   assign req_tready = !busy;
   assign in_fire = req_tvalid && req_tready;
   assign rsp_tvalid = out_valid;
   assign rsp_tdata = {1'b0, data_ff[2:0], completed, status};

   always_ff @(posedge clock) begin
      if (in_fire) begin
         mode_ff <= req_tuser;
         data_ff <= req_tdata[44:0];
      end
   end

   bsra_ctrl #(.NUM_PROCS(NUM_PROCS), .NUM_RES(NUM_RES)) u_ctrl (
      .clock(clock), .reset(reset), .in_fire(in_fire), .mode(mode_ff),
      .proc_id(data_ff[2:0]), .res_id(data_ff[4:3]), .sts(sts),
      .out_take(rsp_tready), .ctl(ctl), .proc_sel(proc_sel), .res_sel(res_sel),
      .busy(busy), .out_valid(out_valid), .status(status), .completed(completed)
   );

   bsra_datapath #(.NUM_PROCS(NUM_PROCS), .NUM_RES(NUM_RES), .UNIT_BITS(UNIT_BITS))
   u_dp (
      .clock(clock), .reset(reset), .ctl(ctl), .proc_sel(proc_sel), .res_sel(res_sel),
      .mode(mode_ff), .proc_id(data_ff[2:0]), .res_id(data_ff[4:3]),
      .load_value(data_ff[12:5]), .req_vec(data_ff[44:13]),
      .sts(sts)
   );

   `ASSERT_NEXT(a_busy_after_take, clock, reset, in_fire, busy)
   `ASSERT_IMPL(a_cmp_granted, clock, reset, rsp_tvalid && completed,
                status == ST_GRANTED)
   `ASSERT_NEXT(a_idle_after_beat, clock, reset, rsp_tvalid && rsp_tready, req_tready)
endmodule

FILE: rtl/core/bsra_datapath.sv
module bsra_datapath
   import bsra_pkg::*;
#(
   parameter int NUM_PROCS = NUM_PROCS_DEF,
   parameter int NUM_RES = NUM_RES_DEF,
   parameter int UNIT_BITS = UNIT_BITS_DEF,
   localparam int PW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1,
   localparam int RW = (NUM_RES > 1) ? $clog2(NUM_RES) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ctl_type               ctl,
   input  logic [PW-1:0]         proc_sel,
   input  logic [RW-1:0]         res_sel,
   input  logic [MODE_W-1:0]     mode,
   input  logic [PROC_W-1:0]     proc_id,
   input  logic [RES_W-1:0]      res_id,
   input  logic [IN_UNIT_W-1:0]  load_value,
   input  logic [4*IN_UNIT_W-1:0] req_vec,
   output sts_type               sts
);
   localparam logic [UNIT_BITS-1:0] UMAX = {UNIT_BITS{1'b1}};
   localparam int SW = UNIT_BITS + PW + 1;

   logic [UNIT_BITS-1:0] avail_ff [NUM_RES];
   logic [UNIT_BITS-1:0] alloc_ff [NUM_PROCS][NUM_RES];
   logic [UNIT_BITS-1:0] max_ff   [NUM_PROCS][NUM_RES];
   logic [UNIT_BITS-1:0] need_ff  [NUM_PROCS][NUM_RES];
   logic [NUM_PROCS-1:0] fin_ff;
   logic [UNIT_BITS-1:0] work_ff  [NUM_RES];
   logic [NUM_PROCS-1:0] wfin_ff;
   logic [SW-1:0]        sum_ff, sum_in;
   logic [UNIT_BITS-1:0] val_sat;
   logic [UNIT_BITS-1:0] req_u [NUM_RES];
   logic [PW-1:0]        pi;
   logic [RW-1:0]        ri;
   logic                 fits;
   logic [UNIT_BITS:0]   wsum [NUM_RES];
   logic [UNIT_BITS+1:0] anew;

   assign pi = proc_id[PW-1:0];
   assign ri = res_id[RW-1:0];

   always_comb begin
      if ({8'd0, load_value} > 16'(UMAX)) val_sat = UMAX;
      else val_sat = UNIT_BITS'(load_value);
      for (int r = 0; r < NUM_RES; r++) begin
         if ({8'd0, req_vec[r*IN_UNIT_W +: IN_UNIT_W]} > 16'(UMAX)) req_u[r] = UMAX;
         else req_u[r] = UNIT_BITS'(req_vec[r*IN_UNIT_W +: IN_UNIT_W]);
      end
   end

   always_comb begin
      sts.over_need = 1'b0;
      sts.over_avail = 1'b0;
      sts.done_cand = !fin_ff[pi];
      fits = !wfin_ff[proc_sel];
      for (int r = 0; r < NUM_RES; r++) begin
         if ({8'd0, req_vec[r*IN_UNIT_W +: IN_UNIT_W]} > 16'(need_ff[pi][r]))
            sts.over_need = 1'b1;
         if ({8'd0, req_vec[r*IN_UNIT_W +: IN_UNIT_W]} > 16'(avail_ff[r]))
            sts.over_avail = 1'b1;
         if (need_ff[proc_sel][r] > work_ff[r]) fits = 1'b0;
         if (alloc_ff[pi][r] < max_ff[pi][r]) sts.done_cand = 1'b0;
         wsum[r] = {1'b0, work_ff[r]} + {1'b0, alloc_ff[proc_sel][r]};
      end
      sts.scan_fit = fits;
      sts.all_done = &wfin_ff;
      sum_in = sum_ff + SW'(alloc_ff[proc_sel][ri]);
      anew = {2'b0, avail_ff[ri]} + {2'b0, alloc_ff[pi][ri]} - {2'b0, val_sat};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ff <= '0;
         wfin_ff <= '0;
         sum_ff <= '0;
         for (int r = 0; r < NUM_RES; r++) begin
            avail_ff[r] <= '0;
            work_ff[r] <= '0;
            for (int p = 0; p < NUM_PROCS; p++) begin
               alloc_ff[p][r] <= '0;
               max_ff[p][r] <= '0;
               need_ff[p][r] <= '0;
            end
         end
      end else begin
         if (ctl.sum_clr) sum_ff <= '0;
         if (ctl.sum_step) sum_ff <= sum_in;
         if (ctl.set_total)
            avail_ff[ri] <= (SW'(val_sat) > sum_ff) ? UNIT_BITS'(SW'(val_sat) - sum_ff) : '0;
         if (ctl.load_cell) begin
            fin_ff[pi] <= 1'b0;
            if (mode == MODE_MAX) max_ff[pi][ri] <= val_sat;
            else begin
               alloc_ff[pi][ri] <= val_sat;
               if (anew[UNIT_BITS+1]) avail_ff[ri] <= '0;
               else if (anew[UNIT_BITS]) avail_ff[ri] <= UMAX;
               else avail_ff[ri] <= anew[UNIT_BITS-1:0];
            end
         end
         if (ctl.need_step) begin
            if (fin_ff[pi] || alloc_ff[pi][res_sel] >= max_ff[pi][res_sel])
               need_ff[pi][res_sel] <= '0;
            else
               need_ff[pi][res_sel] <= max_ff[pi][res_sel] - alloc_ff[pi][res_sel];
         end
         if (ctl.apply_req || ctl.undo_req) begin
            for (int r = 0; r < NUM_RES; r++) begin
               if (ctl.apply_req) begin
                  avail_ff[r] <= avail_ff[r] - req_u[r];
                  alloc_ff[pi][r] <= alloc_ff[pi][r] + req_u[r];
                  need_ff[pi][r] <= need_ff[pi][r] - req_u[r];
               end else begin
                  avail_ff[r] <= avail_ff[r] + req_u[r];
                  alloc_ff[pi][r] <= alloc_ff[pi][r] - req_u[r];
                  need_ff[pi][r] <= need_ff[pi][r] + req_u[r];
               end
            end
         end
         if (ctl.scan_init) begin
            wfin_ff <= fin_ff;
            for (int r = 0; r < NUM_RES; r++)
               work_ff[r] <= ctl.apply_req ? avail_ff[r] - req_u[r] : avail_ff[r];
         end
         if (ctl.scan_step && fits) begin
            wfin_ff[proc_sel] <= 1'b1;
            for (int r = 0; r < NUM_RES; r++)
               work_ff[r] <= wsum[r][UNIT_BITS] ? UMAX : wsum[r][UNIT_BITS-1:0];
         end
         if (ctl.rel_step) begin
            avail_ff[res_sel] <= ({1'b0, avail_ff[res_sel]} + {1'b0, alloc_ff[pi][res_sel]}
                                  > {1'b0, UMAX}) ? UMAX
                                 : avail_ff[res_sel] + alloc_ff[pi][res_sel];
            alloc_ff[pi][res_sel] <= '0;
            need_ff[pi][res_sel] <= '0;
         end
         if (ctl.mark_fin) fin_ff[pi] <= 1'b1;
      end
   end
endmodule

FILE: rtl/core/bsra_ctrl.sv
module bsra_ctrl
   import bsra_pkg::*;
#(
   parameter int NUM_PROCS = NUM_PROCS_DEF,
   parameter int NUM_RES = NUM_RES_DEF,
   localparam int PW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1,
   localparam int RW = (NUM_RES > 1) ? $clog2(NUM_RES) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_fire,
   input  logic [MODE_W-1:0]   mode,
   input  logic [PROC_W-1:0]   proc_id,
   input  logic [RES_W-1:0]    res_id,
   input  sts_type             sts,
   input  logic                out_take,
   output ctl_type             ctl,
   output logic [PW-1:0]       proc_sel,
   output logic [RW-1:0]       res_sel,
   output logic                busy,
   output logic                out_valid,
   output logic [STATUS_W-1:0] status,
   output logic                completed
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SUM  = 3'd1;
   localparam logic [2:0] S_NEED = 3'd2;
   localparam logic [2:0] S_SCAN = 3'd3;
   localparam logic [2:0] S_REL  = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;
   localparam logic [2:0] S_DEC  = 3'd6;
   localparam logic [2:0] S_TOT  = 3'd7;

   logic [2:0]          state_ff, state_in;
   logic [PW-1:0]       p_ff, p_in;
   logic [RW-1:0]       r_ff, r_in;
   logic                prog_ff, prog_in;
   logic [STATUS_W-1:0] st_ff, st_in;
   logic                cmp_ff, cmp_in;
   logic                p_ok, r_ok, last_p, last_r;

   assign p_ok = 32'(proc_id) < NUM_PROCS;
   assign r_ok = 32'(res_id) < NUM_RES;
   assign last_p = 32'(p_ff) == NUM_PROCS - 1;
   assign last_r = 32'(r_ff) == NUM_RES - 1;
   assign proc_sel = p_ff;
   assign res_sel = r_ff;
   assign busy = state_ff != S_IDLE;
   assign out_valid = state_ff == S_OUT;
   assign status = st_ff;
   assign completed = cmp_ff;

   always_comb begin
      state_in = state_ff;
      p_in = p_ff;
      r_in = r_ff;
      prog_in = prog_ff;
      st_in = st_ff;
      cmp_in = cmp_ff;
      ctl = '0;
      case (state_ff)
         S_IDLE: begin
            if (in_fire) begin
               ctl.load = 1'b1;
               st_in = ST_LOADED;
               cmp_in = 1'b0;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            p_in = '0;
            r_in = '0;
            state_in = S_OUT;
            case (mode)
               MODE_TOTAL: if (r_ok) begin
                  ctl.sum_clr = 1'b1;
                  r_in = res_id[RW-1:0];
                  state_in = S_SUM;
               end
               MODE_MAX, MODE_ALLOC: if (p_ok && r_ok) begin
                  ctl.load_cell = 1'b1;
                  state_in = S_NEED;
               end
               MODE_REQ: begin
                  if (!p_ok || sts.over_need) st_in = ST_OVER_NEED;
                  else if (sts.over_avail) st_in = ST_UNAVAIL;
                  else begin
                     ctl.apply_req = 1'b1;
                     ctl.scan_init = 1'b1;
                     prog_in = 1'b0;
                     state_in = S_SCAN;
                  end
               end
               MODE_CHECK: begin
                  ctl.scan_init = 1'b1;
                  prog_in = 1'b0;
                  state_in = S_SCAN;
               end
               default: ;
            endcase
         end
         S_SUM: begin
            ctl.sum_step = 1'b1;
            p_in = p_ff + 1'b1;
            if (last_p) begin
               p_in = '0;
               state_in = S_TOT;
            end
         end
         S_TOT: begin
            ctl.set_total = 1'b1;
            state_in = S_OUT;
         end
         S_NEED: begin
            ctl.need_step = 1'b1;
            r_in = r_ff + 1'b1;
            if (last_r) begin
               r_in = '0;
               state_in = S_OUT;
            end
         end
         S_SCAN: begin
            ctl.scan_step = 1'b1;
            p_in = p_ff + 1'b1;
            if (sts.scan_fit) begin
               p_in = '0;
               prog_in = 1'b1;
            end else if (last_p) begin
               p_in = '0;
               if (prog_ff) prog_in = 1'b0;
               else begin
                  if (mode == MODE_CHECK) begin
                     st_in = sts.all_done ? ST_SAFE : ST_DEADLOCK;
                     state_in = S_OUT;
                  end else if (!sts.all_done) begin
                     ctl.undo_req = 1'b1;
                     st_in = ST_UNSAFE;
                     state_in = S_OUT;
                  end else begin
                     st_in = ST_GRANTED;
                     if (sts.done_cand) begin
                        cmp_in = 1'b1;
                        r_in = '0;
                        state_in = S_REL;
                     end else state_in = S_OUT;
                  end
               end
            end
         end
         S_REL: begin
            ctl.rel_step = 1'b1;
            r_in = r_ff + 1'b1;
            if (last_r) begin
               r_in = '0;
               ctl.mark_fin = 1'b1;
               state_in = S_OUT;
            end
         end
         S_OUT: if (out_take) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
      if (last_p && state_ff == S_SCAN && sts.scan_fit) p_in = '0;
      if (last_p && state_ff == S_SUM) p_in = '0;
      if (state_ff == S_SUM && last_p) r_in = r_ff;
      if (state_ff == S_SCAN) r_in = (state_in == S_REL) ? '0 : r_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         p_ff <= '0;
         r_ff <= '0;
         prog_ff <= 1'b0;
         st_ff <= ST_LOADED;
         cmp_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         p_ff <= p_in;
         r_ff <= r_in;
         prog_ff <= prog_in;
         st_ff <= st_in;
         cmp_ff <= cmp_in;
      end
   end
endmodule

FILE: tb/bankers_safe_resource_allocator_unit_tb.sv
`timescale 1ns / 1ps
module bankers_safe_resource_allocator_unit_tb;
   import bsra_pkg::*;

   localparam int NP = NUM_PROCS_DEF;
   localparam int NR = NUM_RES_DEF;
   localparam int UMAX = (1 << UNIT_BITS_DEF) - 1;
   localparam int IDLE_LIMIT = 4000;
   localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
   localparam logic [MODE_W-1:0] MODE_SPARE_LAST = 3'd7;

   typedef struct {
      logic [MODE_W-1:0] mode;
      logic [PROC_W-1:0] proc_id;
      logic [RES_W-1:0]  res_id;
      logic [7:0]        load_value;
      logic [7:0]        amount [NR];
   } alloc_item_type;

   typedef struct packed {
      logic [PROC_W-1:0]   proc_echo;
      logic                completed;
      logic [STATUS_W-1:0] status;
   } alloc_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;  // proc_id, res_id, load_value, request_0..3
   logic [2:0]  req_tuser = '0;  // mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;       // status, completed, proc_echo, zero pad

   logic [7:0] avail_m [NR];
   logic [7:0] alloc_m [NP][NR];
   logic [7:0] max_m   [NP][NR];
   logic [7:0] need_m  [NP][NR];
   logic       fin_m   [NP];

   alloc_rsp_type pending_rsp [$];
   int         mismatches = 0;
   int         burst_left = 0;
   int         idle_cycles = 0;
   int         cyc = 0;

   bankers_safe_resource_allocator_unit i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #6 clock = ~clock;

   function automatic void refresh_need(int p);
      for (int r = 0; r < NR; r++) begin
         if (fin_m[p] || alloc_m[p][r] >= max_m[p][r]) need_m[p][r] = '0;
         else need_m[p][r] = max_m[p][r] - alloc_m[p][r];
      end
   endfunction

   function automatic bit state_is_safe();
      int  work [NR];
      bit  done [NP];
      bit  progress;
      bit  fits;
      for (int r = 0; r < NR; r++) work[r] = int'(avail_m[r]);
      for (int p = 0; p < NP; p++) done[p] = fin_m[p];
      progress = 1'b1;
      while (progress) begin
         progress = 1'b0;
         for (int p = 0; p < NP && !progress; p++) begin
            if (!done[p]) begin
               fits = 1'b1;
               for (int r = 0; r < NR; r++) if (int'(need_m[p][r]) > work[r]) fits = 1'b0;
               if (fits) begin
                  done[p] = 1'b1;
                  for (int r = 0; r < NR; r++) begin
                     work[r] += int'(alloc_m[p][r]);
                     if (work[r] > UMAX) work[r] = UMAX;
                  end
                  progress = 1'b1;
               end
            end
         end
      end
      for (int p = 0; p < NP; p++) if (!done[p]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic alloc_rsp_type predict_outcome(alloc_item_type it);
      alloc_rsp_type o;
      int p;
      int rs;
      int sum;
      int a;
      bit over_need;
      bit over_avail;
      bit done;
      p = int'(it.proc_id);
      rs = int'(it.res_id);
      o.status = ST_LOADED;
      o.completed = 1'b0;
      o.proc_echo = it.proc_id;
      case (it.mode)
         MODE_TOTAL: begin
            sum = 0;
            for (int q = 0; q < NP; q++) sum += int'(alloc_m[q][rs]);
            a = int'(it.load_value) - sum;
            avail_m[rs] = (a > 0) ? 8'(a) : 8'd0;
         end
         MODE_MAX, MODE_ALLOC: begin
            if (it.mode == MODE_MAX) max_m[p][rs] = it.load_value;
            else begin
               a = int'(avail_m[rs]) + int'(alloc_m[p][rs]) - int'(it.load_value);
               if (a < 0) a = 0;
               if (a > UMAX) a = UMAX;
               avail_m[rs] = 8'(a);
               alloc_m[p][rs] = it.load_value;
            end
            fin_m[p] = 1'b0;
            refresh_need(p);
         end
         MODE_REQ: begin
            over_need = 1'b0;
            over_avail = 1'b0;
            for (int r = 0; r < NR; r++) begin
               if (it.amount[r] > need_m[p][r]) over_need = 1'b1;
               if (it.amount[r] > avail_m[r]) over_avail = 1'b1;
            end
            if (over_need) o.status = ST_OVER_NEED;
            else if (over_avail) o.status = ST_UNAVAIL;
            else begin
               for (int r = 0; r < NR; r++) begin
                  avail_m[r] -= it.amount[r];
                  alloc_m[p][r] += it.amount[r];
                  need_m[p][r] -= it.amount[r];
               end
               if (!state_is_safe()) begin
                  for (int r = 0; r < NR; r++) begin
                     avail_m[r] += it.amount[r];
                     alloc_m[p][r] -= it.amount[r];
                     need_m[p][r] += it.amount[r];
                  end
                  o.status = ST_UNSAFE;
               end else begin
                  o.status = ST_GRANTED;
                  done = !fin_m[p];
                  for (int r = 0; r < NR; r++) if (alloc_m[p][r] < max_m[p][r]) done = 1'b0;
                  if (done) begin
                     for (int r = 0; r < NR; r++) begin
                        a = int'(avail_m[r]) + int'(alloc_m[p][r]);
                        avail_m[r] = (a > UMAX) ? 8'(UMAX) : 8'(a);
                        alloc_m[p][r] = '0;
                     end
                     fin_m[p] = 1'b1;
                     refresh_need(p);
                     o.completed = 1'b1;
                  end
               end
            end
         end
         MODE_CHECK: o.status = state_is_safe() ? ST_SAFE : ST_DEADLOCK;
         default: ;
      endcase
      return o;
   endfunction

   task automatic send_item(alloc_item_type it);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 10);
      end
      burst_left--;
      pending_rsp.push_back(predict_outcome(it));
      req_tvalid <= 1'b1;
      req_tuser <= it.mode;
      req_tdata <= {3'b000, it.amount[3], it.amount[2], it.amount[1], it.amount[0],
                    it.load_value, it.res_id, it.proc_id};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
   endtask

   task automatic send_fields(logic [2:0] mode, int p, int rs, int val,
                              int r0 = 0, int r1 = 0, int r2 = 0, int r3 = 0);
      alloc_item_type it;
      it.mode = mode;
      it.proc_id = PROC_W'(p);
      it.res_id = RES_W'(rs);
      it.load_value = 8'(val);
      it.amount[0] = 8'(r0);
      it.amount[1] = 8'(r1);
      it.amount[2] = 8'(r2);
      it.amount[3] = 8'(r3);
      send_item(it);
   endtask

   task automatic send_noise();
      alloc_item_type it;
      it.mode = MODE_W'($urandom_range(0, 7));
      it.proc_id = PROC_W'($urandom);
      it.res_id = RES_W'($urandom);
      it.load_value = 8'($urandom);
      for (int r = 0; r < NR; r++) it.amount[r] = 8'($urandom);
      send_item(it);
   endtask

   task automatic test_reset_state();
      send_fields(MODE_CHECK, 0, 0, 0);
      send_fields(MODE_REQ, 7, 0, 0);
      send_fields(MODE_REQ, 1, 0, 0, 1, 0, 0, 0);
   endtask

   task automatic test_loads_and_denials();
      send_fields(MODE_TOTAL, 0, 0, 255);
      send_fields(MODE_TOTAL, 0, 1, 0);
      send_fields(MODE_TOTAL, 0, 2, 10);
      send_fields(MODE_TOTAL, 0, 3, 10);
      send_fields(MODE_MAX, 0, 0, 255);
      send_fields(MODE_MAX, 0, 2, 8);
      send_fields(MODE_ALLOC, 0, 2, 3);
      send_fields(MODE_MAX, 1, 2, 9);
      send_fields(MODE_ALLOC, 1, 3, 200);
      send_fields(MODE_REQ, 0, 0, 0, 0, 0, 6, 0);
      send_fields(MODE_REQ, 0, 0, 0, 0, 1, 0, 0);
      send_fields(MODE_REQ, 1, 0, 0, 0, 0, 9, 0);
      send_fields(MODE_REQ, 1, 0, 0, 0, 0, 7, 0);
      send_fields(MODE_CHECK, 0, 0, 0);
      send_fields(MODE_REQ, 0, 0, 0, 255, 0, 5, 0);
      send_fields(MODE_REQ, 0, 0, 0, 0, 0, 0, 0);
      send_fields(MODE_REQ, 0, 0, 0, 1, 0, 0, 0);
      send_fields(MODE_SPARE_FIRST, 5, 1, 77, 255, 255, 255, 255);
      send_fields(MODE_SPARE_LAST, 6, 3, 255);
      send_fields(MODE_CHECK, 3, 0, 0);
   endtask

   task automatic test_random_sessions();
      int n;
      int p;
      int r_amt [NR];
      n = 0;
      while (n < 750) begin
         for (int r = 0; r < NR; r++) begin
            send_fields(MODE_TOTAL, 0, r,
                        ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                                    : $urandom_range(0, 30));
            n++;
         end
         for (int q = 0; q < NP; q++) begin
            if ($urandom_range(0, 3) != 0) begin
               for (int r = 0; r < NR; r++) begin
                  send_fields(MODE_MAX, q, r, $urandom_range(0, 20));
                  n++;
                  if ($urandom_range(0, 1) == 0) begin
                     send_fields(MODE_ALLOC, q, r, $urandom_range(0, max_m[q][r]));
                     n++;
                  end
               end
            end
         end
         repeat ($urandom_range(10, 30)) begin
            p = $urandom_range(0, NP - 1);
            case ($urandom_range(0, 9))
               0: send_noise();
               1: send_fields(MODE_CHECK, p, 0, 0);
               2: send_fields(MODE_REQ, p, 0, 0, need_m[p][0], need_m[p][1],
                              need_m[p][2], need_m[p][3]);
               default: begin
                  for (int r = 0; r < NR; r++) r_amt[r] = $urandom_range(0, need_m[p][r]);
                  if ($urandom_range(0, 7) == 0) r_amt[$urandom_range(0, NR - 1)] += 1;
                  send_fields(MODE_REQ, p, 0, 0, r_amt[0], r_amt[1], r_amt[2], r_amt[3]);
               end
            endcase
            n++;
         end
      end
   endtask

   always @(posedge clock) begin
      cyc <= cyc + 1;
      case ((cyc / 97) % 3)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   always @(posedge clock) begin
      alloc_rsp_type got;
      alloc_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[6:0];
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat: %h", rsp_tdata);
         end else begin
            want = pending_rsp.pop_front();
            if (got.status !== want.status || got.completed !== want.completed
                || got.proc_echo !== want.proc_echo) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("status %0d/%0d completed %0d/%0d proc %0d/%0d (exp/got)",
                           want.status, got.status, want.completed, got.completed,
                           want.proc_echo, got.proc_echo);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("bankers_safe_resource_allocator_unit: mismatch");
         $finish;
      end else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      for (int r = 0; r < NR; r++) avail_m[r] = '0;
      for (int p = 0; p < NP; p++) begin
         fin_m[p] = 1'b0;
         for (int r = 0; r < NR; r++) begin
            alloc_m[p][r] = '0;
            max_m[p][r] = '0;
            need_m[p][r] = '0;
         end
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_loads_and_denials();
      test_random_sessions();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0)
         $display("bankers_safe_resource_allocator_unit: match");
      else
         $display("bankers_safe_resource_allocator_unit: mismatch");
      $finish;
   end
endmodule
